>>> sv/pdba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdba_pkg
// shared widths, register codes, reset values and the close request struct
// ----------------------------------------------------------------------------
package pdba_pkg;

    // default sizes of the palette store
    localparam int MAX_IMAGES_DEF    = 32;
    localparam int PALETTE_WORDS_DEF = 16;

    // fixed field widths
    localparam int COLOR_W     = 16;
    localparam int WORD_IDX_W  = 4;
    localparam int BANK_W      = 4;
    localparam int BANK_CNT_W  = 5;
    localparam int IMG_NUM_W   = 8;
    localparam int IDX_EXT_W   = 9;

    // configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_ADDR_W-1:0] REG_FIRST_BANK    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_BANK_COUNT    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_FALLBACK_BANK = 2'd2;

    localparam logic [BANK_W-1:0]     FIRST_BANK_RST    = 4'd4;
    localparam logic [BANK_CNT_W-1:0] BANK_COUNT_RST    = 5'd12;
    localparam logic [BANK_W-1:0]     FALLBACK_BANK_RST = 4'd1;

    localparam logic [IMG_NUM_W-1:0]  IMG_NUM_MAX = 8'hFF;

    // handed from the scan sequencer to the allocator in the finish cycle
    typedef struct packed {
        logic              fire;
        logic              found;
        logic [BANK_W-1:0] match_bank;
        logic              store_full;
    } close_req_t;

endpackage

>>> sv/pdba_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdba_store
// palette store: one row per image, palette words plus its bank
// ----------------------------------------------------------------------------
module pdba_store #(
    parameter int DEPTH = pdba_pkg::MAX_IMAGES_DEF,
    parameter int WIDTH = pdba_pkg::PALETTE_WORDS_DEF * pdba_pkg::COLOR_W
                          + pdba_pkg::BANK_W
) (
    input  logic                                 clk,
    input  logic                                 wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                     wr_data,
    input  logic                                 rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/pdba_alloc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdba_alloc
// bank allocator: config registers, bank and image counters, result register
// ----------------------------------------------------------------------------
module pdba_alloc (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [pdba_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [pdba_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  pdba_pkg::close_req_t                close,
    output logic [pdba_pkg::BANK_W-1:0]         grant_bank,
    output logic                                done,
    output logic [pdba_pkg::IMG_NUM_W-1:0]      image_number,
    output logic [pdba_pkg::BANK_W-1:0]         bank,
    output logic                                newly_assigned,
    output logic                                fell_back,
    output logic                                not_stored
);

    logic [pdba_pkg::BANK_W-1:0]     first_bank_reg;
    logic [pdba_pkg::BANK_CNT_W-1:0] bank_count_reg;
    logic [pdba_pkg::BANK_W-1:0]     fallback_bank_reg;
    logic [pdba_pkg::BANK_CNT_W-1:0] banks_used_reg, banks_used_next;
    logic [pdba_pkg::IMG_NUM_W-1:0]  images_seen_reg, images_seen_next;

    logic                            done_reg;
    logic [pdba_pkg::IMG_NUM_W-1:0]  image_number_reg;
    logic [pdba_pkg::BANK_W-1:0]     bank_reg;
    logic                            fresh_reg, fresh_next;
    logic                            fell_reg, fell_next;
    logic                            dropped_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_bank_reg    <= pdba_pkg::FIRST_BANK_RST;
            bank_count_reg    <= pdba_pkg::BANK_COUNT_RST;
            fallback_bank_reg <= pdba_pkg::FALLBACK_BANK_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_addr)
                pdba_pkg::REG_FIRST_BANK:
                    first_bank_reg <= cfg_wdata[pdba_pkg::BANK_W-1:0];
                pdba_pkg::REG_BANK_COUNT:
                    bank_count_reg <= cfg_wdata;
                pdba_pkg::REG_FALLBACK_BANK:
                    fallback_bank_reg <= cfg_wdata[pdba_pkg::BANK_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // bank decision and image count for the closing image
    always_comb
    begin
        grant_bank      = close.match_bank;
        fresh_next      = 1'b0;
        fell_next       = 1'b0;
        banks_used_next = banks_used_reg;
        if (!close.found)
        begin
            if (banks_used_reg >= bank_count_reg)
            begin
                grant_bank = fallback_bank_reg;
                fell_next  = 1'b1;
            end
            else
            begin
                grant_bank      = first_bank_reg + banks_used_reg[pdba_pkg::BANK_W-1:0];
                banks_used_next = banks_used_reg + 1'b1;
                fresh_next      = 1'b1;
            end
        end
        images_seen_next = images_seen_reg;
        if (images_seen_reg != pdba_pkg::IMG_NUM_MAX)
        begin
            images_seen_next = images_seen_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            banks_used_reg  <= '0;
            images_seen_reg <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            done_reg <= close.fire;
            if (close.fire)
            begin
                banks_used_reg  <= banks_used_next;
                images_seen_reg <= images_seen_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (close.fire)
        begin
            image_number_reg <= images_seen_reg;
            bank_reg         <= grant_bank;
            fresh_reg        <= fresh_next;
            fell_reg         <= fell_next;
            dropped_reg      <= close.store_full;
        end
    end

    assign done           = done_reg;
    assign image_number   = image_number_reg;
    assign bank           = bank_reg;
    assign newly_assigned = fresh_reg;
    assign fell_back      = fell_reg;
    assign not_stored     = dropped_reg;

endmodule

>>> sv/palette_dedup_bank_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_dedup_bank_allocator
// assigns palette banks to images, reusing the bank of an identical palette
// ----------------------------------------------------------------------------
// Palette words are taken with start while busy is low. A word that does not
// close the palette is taken as it is offered and busy stays low. The closing
// word raises busy while the stored palettes are walked one row per cycle
// through the palette store's single read port, until a match is found or
// every stored row has been checked; with the store empty, the scan is
// skipped. The result shows on done for exactly one cycle, the first cycle
// with busy low again; it cannot be held off, and the next palette word may be
// taken in that same cycle. Configuration writes are taken at any edge with
// cfg_write high and belong in idle time between palettes.
module palette_dedup_bank_allocator #(
    parameter int MAX_IMAGES    = pdba_pkg::MAX_IMAGES_DEF,
    parameter int PALETTE_WORDS = pdba_pkg::PALETTE_WORDS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // palette word transfer
    input  logic                                start,
    output logic                                busy,
    input  logic [pdba_pkg::COLOR_W-1:0]        color_word,
    input  logic [pdba_pkg::WORD_IDX_W-1:0]     word_index,
    // result transfer
    output logic                                done,
    output logic [pdba_pkg::IMG_NUM_W-1:0]      image_number,
    output logic [pdba_pkg::BANK_W-1:0]         bank,
    output logic                                newly_assigned,
    output logic                                fell_back,
    output logic                                not_stored,
    // configuration writes
    input  logic                                cfg_write,
    input  logic [pdba_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [pdba_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int CW     = $clog2(MAX_IMAGES + 1);
    localparam int AW     = (MAX_IMAGES > 1) ? $clog2(MAX_IMAGES) : 1;
    localparam int PWW    = (PALETTE_WORDS > 1) ? $clog2(PALETTE_WORDS) : 1;
    localparam int PAL_W  = PALETTE_WORDS * pdba_pkg::COLOR_W;
    localparam int ROW_W  = PAL_W + pdba_pkg::BANK_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0] state_reg, state_next;

    // palette being collected
    logic [pdba_pkg::COLOR_W-1:0] cur_pal_reg [PALETTE_WORDS];
    logic [PAL_W-1:0]             pal_row;

    logic [pdba_pkg::IDX_EXT_W-1:0] idx_ext;
    logic                           accept;
    logic                           word_ok;
    logic                           closing;

    // scan control
    logic [CW-1:0] stored_reg, stored_next;
    logic [CW-1:0] issue_addr_reg, issue_addr_next, issue_addr_inc;
    logic          issued_all_reg, issued_all_next;
    logic          chk_reg, chk_last_reg;
    logic          found_reg, found_next;
    logic [pdba_pkg::BANK_W-1:0] match_bank_reg, match_bank_next;
    logic          rd_en;
    logic [ROW_W-1:0] rd_row;
    logic          row_match;
    logic          store_full;

    pdba_pkg::close_req_t        close;
    logic [pdba_pkg::BANK_W-1:0] grant_bank;

    assign idx_ext = pdba_pkg::IDX_EXT_W'(word_index);
    assign accept  = start && !busy;
    assign word_ok = idx_ext < pdba_pkg::IDX_EXT_W'(PALETTE_WORDS);
    assign closing = word_ok && (idx_ext == pdba_pkg::IDX_EXT_W'(PALETTE_WORDS - 1));

    assign busy       = (state_reg != ST_IDLE);
    assign store_full = (stored_reg == CW'(MAX_IMAGES));

    // latch each accepted in-range word at its position
    always_ff @(posedge clk)
    begin
        if (accept && word_ok)
        begin
            cur_pal_reg[idx_ext[PWW-1:0]] <= color_word;
        end
    end

    always_comb
    begin
        for (int k = 0; k < PALETTE_WORDS; k++)
        begin
            pal_row[k*pdba_pkg::COLOR_W +: pdba_pkg::COLOR_W] = cur_pal_reg[k];
        end
    end

    // compare the row read in the previous cycle against the collected palette
    assign row_match      = (rd_row[PAL_W-1:0] == pal_row);
    assign issue_addr_inc = issue_addr_reg + 1'b1;

    always_comb
    begin
        state_next      = state_reg;
        stored_next     = stored_reg;
        issue_addr_next = issue_addr_reg;
        issued_all_next = issued_all_reg;
        found_next      = found_reg;
        match_bank_next = match_bank_reg;
        rd_en           = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && closing)
                begin
                    issue_addr_next = '0;
                    issued_all_next = 1'b0;
                    found_next      = 1'b0;
                    state_next      = (stored_reg == '0) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // one read issued per cycle, checked the cycle after
                if (!issued_all_reg)
                begin
                    rd_en           = 1'b1;
                    issue_addr_next = issue_addr_inc;
                    issued_all_next = (issue_addr_inc == stored_reg);
                end
                if (chk_reg && row_match)
                begin
                    found_next      = 1'b1;
                    match_bank_next = rd_row[ROW_W-1:PAL_W];
                    state_next      = ST_FINISH;
                end
                else if (chk_reg && chk_last_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // store write (unless the store is full) and allocation happen here
                if (!store_full)
                begin
                    stored_next = stored_reg + 1'b1;
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            stored_reg     <= '0;
            issue_addr_reg <= '0;
            issued_all_reg <= 1'b0;
            chk_reg        <= 1'b0;
            chk_last_reg   <= 1'b0;
            found_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            stored_reg     <= stored_next;
            issue_addr_reg <= issue_addr_next;
            issued_all_reg <= issued_all_next;
            chk_reg        <= rd_en;
            chk_last_reg   <= rd_en && (issue_addr_inc == stored_reg);
            found_reg      <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        match_bank_reg <= match_bank_next;
    end

    assign close.fire       = (state_reg == ST_FINISH);
    assign close.found      = found_reg;
    assign close.match_bank = match_bank_reg;
    assign close.store_full = store_full;

    // store: row written once per stored image, read row by row when scanning
    pdba_store #(
        .DEPTH (MAX_IMAGES),
        .WIDTH (ROW_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (close.fire && !store_full),
        .wr_addr (stored_reg[AW-1:0]),
        .wr_data ({grant_bank, pal_row}),
        .rd_en   (rd_en),
        .rd_addr (issue_addr_reg[AW-1:0]),
        .rd_data (rd_row)
    );

    pdba_alloc u_alloc (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .close          (close),
        .grant_bank     (grant_bank),
        .done           (done),
        .image_number   (image_number),
        .bank           (bank),
        .newly_assigned (newly_assigned),
        .fell_back      (fell_back),
        .not_stored     (not_stored)
    );

endmodule

>>> sv/pdba_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdba_check
// port-level checks of the bank allocator, bound to the top level
// ----------------------------------------------------------------------------
module pdba_check (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            busy,
    input logic                            done,
    input logic                            newly_assigned,
    input logic                            fell_back
);

    // a result always ends a busy stretch
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a preceding busy stretch");

    // every busy stretch ends with exactly one result
    a_busy_end_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy ended without a result");

    // one result per closed palette, never two in a row
    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("back-to-back results");

    // fresh allocation and fallback exclude each other
    a_alloc_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(newly_assigned && fell_back))
        else $error("fresh bank and fallback flagged together");

endmodule

bind palette_dedup_bank_allocator pdba_check u_pdba_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .busy           (busy),
    .done           (done),
    .newly_assigned (newly_assigned),
    .fell_back      (fell_back)
);
